@@ design/bss_pkg.sv @@
// Package for the byte string sorter: shared constants, controller/datapath
// command and status structs, and the signed byte ordering function.
// No dependencies.
package bss_pkg;

    localparam int MAX_LEN_DEFAULT = 64;
    localparam int CHAR_W          = 8;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic insert;   // input item accepted this cycle
        logic shift;    // result item accepted this cycle
    } bss_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_one; // exactly one stored byte remains
    } bss_status_t;

    // True if byte a must come after byte b in the selected order.
    // Flipping the sign bit turns the signed order into an unsigned one.
    function automatic logic bss_goes_after(input logic [CHAR_W-1:0] a,
                                            input logic [CHAR_W-1:0] b,
                                            input logic desc);
        logic [CHAR_W-1:0] ka;
        logic [CHAR_W-1:0] kb;
        ka = {~a[CHAR_W-1], a[CHAR_W-2:0]};
        kb = {~b[CHAR_W-1], b[CHAR_W-2:0]};
        return desc ? (ka < kb) : (ka > kb);
    endfunction

endpackage

@@ design/bss_if.sv @@
// Valid/ready channel interfaces for the byte string sorter.
// Depends on bss_pkg for the character width.
interface bss_byte_if;
    logic                       valid;
    logic                       ready;
    logic [bss_pkg::CHAR_W-1:0] char_in;
    logic                       is_last;

    modport source (output valid, output char_in, output is_last, input ready);
    modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

interface bss_sorted_if;
    logic                       valid;
    logic                       ready;
    logic [bss_pkg::CHAR_W-1:0] char_out;
    logic                       end_of_string;
    logic                       overflow;

    modport source (output valid, output char_out, output end_of_string,
                    output overflow, input ready);
    modport sink   (input valid, input char_out, input end_of_string,
                    input overflow, output ready);
endinterface

@@ design/bss_ctrl.sv @@
// Controller for the byte string sorter: fill/drain state machine that
// drives the channel handshakes and issues commands to the datapath.
// Depends on bss_pkg.
module bss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_is_last,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  bss_pkg::bss_status_t status,
    output bss_pkg::bss_cmd_t    cmd
);
    import bss_pkg::*;

    typedef enum logic [1:0] {
        S_FILL  = 2'b01,
        S_DRAIN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Handshakes follow the state directly
    assign in_ready   = (state_reg == S_FILL);
    assign out_valid  = (state_reg == S_DRAIN);
    assign cmd.insert = in_valid && in_ready;
    assign cmd.shift  = out_valid && out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_FILL:
            begin
                if (cmd.insert && in_is_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (cmd.shift && status.last_one)
                begin
                    state_next = S_FILL;
                end
            end
            default:
            begin
                state_next = S_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/bss_datapath.sv @@
// Datapath for the byte string sorter: a row of insertion cells kept in
// sorted order, the fill count, the overflow flag and the mode register.
// Depends on bss_pkg.
module bss_datapath #(
    parameter int MAX_LEN = bss_pkg::MAX_LEN_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bss_pkg::bss_cmd_t          cmd,
    input  logic [bss_pkg::CHAR_W-1:0] char_in,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    output logic [bss_pkg::CHAR_W-1:0] char_out,
    output logic                       end_of_string,
    output logic                       overflow,
    output bss_pkg::bss_status_t       status
);
    import bss_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CHAR_W-1:0] cell_reg  [MAX_LEN];
    logic [CHAR_W-1:0] cell_next [MAX_LEN];
    logic [MAX_LEN-1:0] gt;
    logic [CW-1:0] count_reg, count_next;
    logic          flag_reg, flag_next;
    logic          desc_reg, desc_next;
    logic          full;

    assign full       = (count_reg == CW'(MAX_LEN));

    // Per-cell compare and next value: the new byte goes into the first
    // cell that must come after it, later cells move up by one.
    for (genvar i = 0; i < MAX_LEN; i++)
    begin : g_cell
        logic occupied;
        logic [CHAR_W-1:0] up_val;
        logic [CHAR_W-1:0] down_val;

        assign occupied    = (CW'(i) < count_reg);
        assign gt[i]       = !occupied || bss_goes_after(cell_reg[i], char_in, desc_reg);

        if (i == 0)
        begin : g_first
            assign up_val = char_in;
        end
        else
        begin : g_rest
            assign up_val = gt[i-1] ? cell_reg[i-1] : char_in;
        end

        if (i == MAX_LEN - 1)
        begin : g_top
            assign down_val = cell_reg[i];
        end
        else
        begin : g_mid
            assign down_val = cell_reg[i+1];
        end

        always_comb
        begin
            cell_next[i] = cell_reg[i];
            if (cmd.insert && !full && gt[i])
            begin
                cell_next[i] = up_val;
            end
            else if (cmd.shift)
            begin
                cell_next[i] = down_val;
            end
        end

        always_ff @(posedge clk)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    // Count, overflow flag and mode register
    always_comb
    begin
        count_next = count_reg;
        flag_next  = flag_reg;
        desc_next  = desc_reg;
        if (cfg_we)
        begin
            desc_next = cfg_wdata;
        end
        if (cmd.insert)
        begin
            if (full)
            begin
                flag_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else if (cmd.shift)
        begin
            count_next = count_reg - CW'(1);
            if (status.last_one)
            begin
                flag_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flag_reg  <= 1'b0;
            desc_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            flag_reg  <= flag_next;
            desc_reg  <= desc_next;
        end
    end

    // Head cell is the next result item
    assign status.last_one = (count_reg == CW'(1));
    assign char_out        = cell_reg[0];
    assign end_of_string   = status.last_one;
    assign overflow        = flag_reg;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LEN))
        else $error("fill count beyond capacity");

    a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift |-> (count_reg != '0))
        else $error("result taken from an empty store");

    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift && status.last_one) |=> (count_reg == '0) && !flag_reg)
        else $error("store not cleared after final result");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.insert && !full) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("stored byte not counted");

endmodule

@@ design/byte_string_sorter.sv @@
// Top level of the byte string sorter: joins the controller and datapath
// to the input, result and configuration ports.
// Depends on bss_pkg, bss_if, bss_ctrl and bss_datapath.
//
// Usage: bytes of a string arrive on byte_in, one item per cycle, with
// is_last set on the final byte. Each byte is placed into its sorted
// position in a row of MAX_LEN cells as it arrives, so input runs at one
// item per cycle. Bytes past MAX_LEN are dropped and every result of that
// string then carries overflow. The cycle after the final byte is taken,
// the sorted bytes leave on sorted_out from the head cell, one item per
// cycle while the receiver is ready; end_of_string marks the last one.
// byte_in is not ready while a string drains; a receiver stall holds the
// head item and freezes the block. cfg_we/cfg_wdata write the descending
// mode (0 ascending, 1 descending, signed byte order); write it only while
// idle, which the block itself does not enforce. Reset empties the store,
// clears overflow and selects ascending order.
module byte_string_sorter #(
    parameter int MAX_LEN = bss_pkg::MAX_LEN_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    bss_byte_if.sink     byte_in,
    bss_sorted_if.source sorted_out,
    input  logic         cfg_we,
    input  logic         cfg_wdata
);
    import bss_pkg::*;

    bss_cmd_t    cmd;
    bss_status_t status;

    bss_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (byte_in.valid),
        .in_is_last (byte_in.is_last),
        .in_ready   (byte_in.ready),
        .out_valid  (sorted_out.valid),
        .out_ready  (sorted_out.ready),
        .status     (status),
        .cmd        (cmd)
    );

    bss_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .char_in       (byte_in.char_in),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .char_out      (sorted_out.char_out),
        .end_of_string (sorted_out.end_of_string),
        .overflow      (sorted_out.overflow),
        .status        (status)
    );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for byte_string_sorter: directed table, then random strings
// checked against a signed-order sorting predictor.
// Depends on bss_pkg, bss_if and the byte_string_sorter RTL.
module testbench;

    import bss_pkg::*;

    localparam int STORE_DEPTH  = MAX_LEN_DEFAULT;
    localparam int WATCHDOG_MAX = 2000;
    localparam int SETTLE_CYC   = 6;
    localparam int PHASE_ITEMS  = 6;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eos;
        logic              ovf;
    } sorted_item_t;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        bit                typed;
        logic [CHAR_W-1:0] typed_ch;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    bss_byte_if   byte_ch();
    bss_sorted_if sorted_ch();

    byte_string_sorter #(
        .MAX_LEN(STORE_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_ch),
        .sorted_out(sorted_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state
    logic [CHAR_W-1:0] held_bytes[$];
    bit                lost_bytes;
    bit                order_desc;
    sorted_item_t      sorted_q[$];

    int fail_count;
    int idle_cycles;
    int bytes_sent;
    int results_checked;
    int strings_done;
    int overflow_strings;
    bit sink_no_stall;
    bit source_no_gap;

    // Directed rows: single-byte strings carry their result typed in
    dir_row_t dir_rows [13] = '{
        '{8'h01, 1'b1, 1'b1, 8'h01},
        '{8'hFF, 1'b1, 1'b1, 8'hFF},
        '{8'h80, 1'b1, 1'b1, 8'h80},
        '{8'h7F, 1'b1, 1'b1, 8'h7F},
        '{8'h01, 1'b0, 1'b0, 8'h00},
        '{8'h80, 1'b0, 1'b0, 8'h00},
        '{8'h7F, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b1, 1'b0, 8'h00},
        '{8'h41, 1'b0, 1'b0, 8'h00},
        '{8'h41, 1'b1, 1'b0, 8'h00},
        '{8'hAA, 1'b0, 1'b0, 8'h00},
        '{8'h55, 1'b1, 1'b0, 8'h00}
    };

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Signed byte order for the selected direction
    function automatic bit sorts_after(input logic [CHAR_W-1:0] a,
                                       input logic [CHAR_W-1:0] b);
        if (order_desc)
            return $signed(a) < $signed(b);
        return $signed(a) > $signed(b);
    endfunction

    // Store one accepted byte; on the final byte queue the sorted string
    task automatic track_byte(input logic [CHAR_W-1:0] ch, input logic last);
        logic [CHAR_W-1:0] ordered[$];
        logic [CHAR_W-1:0] v;
        int                j;
        if (held_bytes.size() < STORE_DEPTH)
            held_bytes.push_back(ch);
        else
            lost_bytes = 1'b1;
        if (last)
        begin
            foreach (held_bytes[i])
            begin
                v = held_bytes[i];
                j = ordered.size();
                ordered.push_back(v);
                while (j > 0 && sorts_after(ordered[j-1], v))
                begin
                    ordered[j] = ordered[j-1];
                    j--;
                end
                ordered[j] = v;
            end
            foreach (ordered[k])
                sorted_q.push_back('{ordered[k], (k == ordered.size() - 1), lost_bytes});
            held_bytes = {};
            lost_bytes = 1'b0;
        end
    endtask

    // Source gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (source_no_gap || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Random byte: extremes, a duplicate-heavy pool, or anything nonzero
    function automatic logic [CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            case ($urandom_range(0, 3))
                0: return 8'h01;
                1: return 8'h7F;
                2: return 8'h80;
                default: return 8'hFF;
            endcase
        end
        if (r < 35)
            return 8'h40 + 8'($urandom_range(0, 3));
        return 8'($urandom_range(1, 255));
    endfunction

    // Drive one item after a gap and wait until it is taken
    task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic last, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            byte_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        byte_ch.valid   <= 1'b1;
        byte_ch.char_in <= ch;
        byte_ch.is_last <= last;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Stop sending and wait until every queued result has arrived
    task automatic drain_results();
        @(negedge clk);
        byte_ch.valid <= 1'b0;
        while (sorted_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Mode write while idle
    task automatic write_mode(input logic desc);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= desc;
        @(negedge clk);
        cfg_we    <= 1'b0;
        order_desc = desc;
    endtask

    // Send one random string of the given length
    task automatic send_string(input int len);
        logic [CHAR_W-1:0] ch;
        for (int i = 0; i < len; i++)
        begin
            ch = pick_char();
            send_byte(ch, (i == len - 1), pick_gap());
            track_byte(ch, (i == len - 1));
        end
    endtask

    // Receiver: random stalls, mostly short, a few long
    initial
    begin
        int stall_left;
        stall_left = 0;
        sorted_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                sorted_ch.ready <= 1'b0;
            else if (sink_no_stall)
                sorted_ch.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                sorted_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                sorted_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 20)
                    stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                             : $urandom_range(8, 40);
            end
        end
    end

    // Result checker and activity counter
    always @(posedge clk)
    begin
        sorted_item_t want;
        bit           moved;
        moved = 1'b0;
        if (rst_n && byte_ch.valid && byte_ch.ready)
            moved = 1'b1;
        if (rst_n && sorted_ch.valid && sorted_ch.ready)
        begin
            moved = 1'b1;
            results_checked++;
            if (sorted_ch.end_of_string)
            begin
                strings_done++;
                if (sorted_ch.overflow)
                    overflow_strings++;
            end
            if (sorted_q.size() == 0)
            begin
                $error("unexpected result item: char_out=%h end_of_string=%b overflow=%b",
                       sorted_ch.char_out, sorted_ch.end_of_string, sorted_ch.overflow);
                fail_count++;
            end
            else
            begin
                want = sorted_q.pop_front();
                if (sorted_ch.char_out !== want.ch)
                begin
                    $error("char_out: expected %h, got %h", want.ch, sorted_ch.char_out);
                    fail_count++;
                end
                if (sorted_ch.end_of_string !== want.eos)
                begin
                    $error("end_of_string: expected %b, got %b", want.eos,
                           sorted_ch.end_of_string);
                    fail_count++;
                end
                if (sorted_ch.overflow !== want.ovf)
                begin
                    $error("overflow: expected %b, got %b", want.ovf, sorted_ch.overflow);
                    fail_count++;
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // Watchdog: too long with nothing accepted
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_MAX)
            @(posedge clk);
        $display("watchdog: no item accepted for %0d cycles", WATCHDOG_MAX);
        $display("Simulation FAILED");
        $finish;
    end

    // Main sequence
    initial
    begin
        int                phase_items;
        int                len;
        int                r;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.char_in = '0;
        byte_ch.is_last = 1'b0;
        order_desc      = 1'b0;
        lost_bytes      = 1'b0;
        fail_count      = 0;
        bytes_sent      = 0;
        results_checked = 0;
        strings_done    = 0;
        overflow_strings = 0;
        sink_no_stall   = 1'b0;
        source_no_gap   = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, once per direction
        for (int pass = 0; pass < 2; pass++)
        begin
            write_mode(pass[0]);
            foreach (dir_rows[i])
            begin
                send_byte(dir_rows[i].ch, dir_rows[i].last, pick_gap());
                if (dir_rows[i].typed)
                    sorted_q.push_back('{dir_rows[i].typed_ch, 1'b1, 1'b0});
                else
                    track_byte(dir_rows[i].ch, dir_rows[i].last);
            end
        end

        // Random phases; phase 3 opens with a full store and one dropped byte
        for (int phase = 0; phase < 4; phase++)
        begin
            write_mode(phase[0] ^ ($urandom_range(0, 3) == 0));
            sink_no_stall = ($urandom_range(0, 3) == 0);
            source_no_gap = ($urandom_range(0, 3) == 0);
            phase_items = 0;
            if (phase == 3)
                send_string(STORE_DEPTH + 1);
            while (phase_items < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    len = $urandom_range(1, 6);
                else if (r < 95)
                    len = $urandom_range(7, 16);
                else
                    len = $urandom_range(30, STORE_DEPTH - 1);
                send_string(len);
                phase_items += len;
            end
        end

        sink_no_stall = 1'b0;
        source_no_gap = 1'b0;
        drain_results();

        $display("sent %0d bytes in both sort directions; checked %0d results", bytes_sent,
                 results_checked);
        $display("completed %0d strings, %0d of them with dropped bytes", strings_done,
                 overflow_strings);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
design/bss_pkg.sv
design/bss_if.sv
design/bss_ctrl.sv
design/bss_datapath.sv
design/byte_string_sorter.sv
tb/sv/testbench.sv
